// ----- rtl/core/giwc_pkg.sv -----
`default_nettype none
package giwc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned WEEK_W  = 6;
  localparam int unsigned MLEN_W  = 5;
  localparam int unsigned BYEAR_W = 15;  // year plus one 400-year cycle
  localparam int unsigned CENT_W  = 8;   // biased year / 100

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // Year bias is one 400-year cycle; the pipeline works on biased year - 1.
  localparam logic [BYEAR_W-1:0] YEAR_BIAS_M1 = 15'd399;

  // floor(a/100) = (a * 20972) >> 21, exact for a < 2^21/48
  localparam logic [BYEAR_W-1:0] RECIP_100    = 15'd20972;
  localparam int unsigned        RECIP_100_SH = 21;
  localparam logic [BYEAR_W-1:0] CENTURY      = 15'd100;

  // floor(v/7) = (v * 586) >> 12, exact for v < 4096/6
  localparam logic [9:0]  RECIP_7    = 10'd586;
  localparam int unsigned RECIP_7_SH = 12;

  localparam logic [DOY_W-1:0]  ISO_BIAS    = 9'd10;
  localparam logic [WEEK_W-1:0] WEEKS_LONG  = 6'd53;
  localparam logic [WEEK_W-1:0] WEEKS_SHORT = 6'd52;
  localparam logic [WEEK_W-1:0] WEEK_FIRST  = 6'd1;

  localparam logic [WD_W-1:0] WD_SUN = 3'd0;
  localparam logic [WD_W-1:0] WD_WED = 3'd3;
  localparam logic [WD_W-1:0] WD_THU = 3'd4;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  typedef struct packed {
    logic [WD_W-1:0] jan1;    // weekday of January 1 of this year
    logic            leap_y;  // this year is leap
    logic            leap_p;  // previous year is leap
  } year_info_t;

  typedef struct packed {
    logic [DOY_W-1:0]  doy;
    logic [MLEN_W-1:0] mlen;
    logic              bad;
  } date_info_t;

  // Residue mod 7 by folding octal digits (8 = 1 mod 7).
  function automatic logic [WD_W-1:0] mod7(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
       + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      mod7 = 3'(s2 - 4'd7);
    end else begin
      mod7 = s2[2:0];
    end
  endfunction

  // Zero for a month outside 1..12.
  function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MLEN_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before m, common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [WEEK_W-1:0] iso_weeks(input logic [WD_W-1:0] jan1,
                                                  input logic leap);
    return (jan1 == WD_THU || (jan1 == WD_WED && leap)) ? WEEKS_LONG : WEEKS_SHORT;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gregorian_iso_week_calculator.sv -----
// Gregorian date to weekday / day of year / ISO-8601 week.
// Input stream: one date per request on in_tdata (year, month, day).
// Output stream: one result per request on out_tdata.
// Five register stages: input, century split, year/date info, weekday,
// output. An accepted request moves through them in that order.
// Throughput is one date per cycle while out_tready stays high; every stage
// is a plain pipeline register with a combinational step, no loops.
// Each stage advances when it is empty or the stage after it moves, so
// in_tready stays high while bubbles remain, even with out_tready low.
// With all five stages full and out_tready low, in_tready drops and the
// held result stays on out_tdata until taken.
// Reset (rst_n low, synchronous) empties the pipeline; data registers are not reset.
// For a bad date weekday, day_of_year and iso_week read 0; month_length
// is 0 for a month outside 1..12; leap_year always follows the year.
`default_nettype none
module gregorian_iso_week_calculator
  import giwc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [13:0] year, [17:14] month, [22:18] day, [23] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] weekday, [11:3] day_of_year, [17:12] iso_week,
  // [22:18] month_length, [23] leap_year, [24] bad_date, [31:25] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // stage 0: input
  logic                v0_r;
  logic [YEAR_W-1:0]   year0_r;
  logic [MONTH_W-1:0]  month0_r;
  logic [DAY_W-1:0]    day0_r;

  // stage 1: century split
  logic                v1_r;
  logic [BYEAR_W-1:0]  prev1_r;
  logic [CENT_W-1:0]   cent1_r;
  logic [MONTH_W-1:0]  month1_r;
  logic [DAY_W-1:0]    day1_r;
  logic [BYEAR_W-1:0]  prev1_nxt;
  logic [29:0]         cent_prod;

  // stage 2: year and date info
  logic                v2_r;
  year_info_t          yinfo2_r;
  date_info_t          dinfo2_r;
  year_info_t          yinfo2_nxt;
  date_info_t          dinfo2_nxt;

  // stage 3: weekday
  logic                v3_r;
  year_info_t          yinfo3_r;
  date_info_t          dinfo3_r;
  logic [WD_W-1:0]     wd3_r;
  logic [DOY_W-1:0]    num3_r;
  logic [WD_W-1:0]     wd3_nxt;
  logic [WD_W-1:0]     wmon;
  logic [DOY_W-1:0]    num3_nxt;

  // stage 4: output
  logic                v4_r;
  logic [WD_W-1:0]     wd4_r;
  logic [DOY_W-1:0]    doy4_r;
  logic [WEEK_W-1:0]   week4_r;
  logic [MLEN_W-1:0]   mlen4_r;
  logic                leap4_r;
  logic                bad4_r;
  logic [WEEK_W-1:0]   week4_nxt;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 0 -> 1
  always_comb begin
    prev1_nxt = BYEAR_W'(year0_r) + YEAR_BIAS_M1;
    cent_prod = 30'(prev1_nxt) * 30'(RECIP_100);
  end

  giwc_year_split u_year_split (
    .prev_year (prev1_r),
    .cent      (cent1_r),
    .info      (yinfo2_nxt)
  );

  giwc_date_check u_date_check (
    .month (month1_r),
    .day   (day1_r),
    .leap  (yinfo2_nxt.leap_y),
    .info  (dinfo2_nxt)
  );

  // weekday from Jan 1 plus ordinal day
  always_comb begin
    wd3_nxt  = mod7(16'(yinfo2_r.jan1) + 16'(dinfo2_r.doy) - 16'd1);
    wmon     = (wd3_nxt == WD_SUN) ? 3'd7 : wd3_nxt;
    num3_nxt = dinfo2_r.doy + ISO_BIAS - DOY_W'(wmon);
  end

  giwc_week_sel u_week_sel (
    .num   (num3_r),
    .yinfo (yinfo3_r),
    .week  (week4_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy0) begin
      year0_r  <= in_tdata[13:0];
      month0_r <= in_tdata[17:14];
      day0_r   <= in_tdata[22:18];
    end
    if (rdy1) begin
      prev1_r  <= prev1_nxt;
      cent1_r  <= cent_prod[RECIP_100_SH +: CENT_W];
      month1_r <= month0_r;
      day1_r   <= day0_r;
    end
    if (rdy2) begin
      yinfo2_r <= yinfo2_nxt;
      dinfo2_r <= dinfo2_nxt;
    end
    if (rdy3) begin
      yinfo3_r <= yinfo2_r;
      dinfo3_r <= dinfo2_r;
      wd3_r    <= wd3_nxt;
      num3_r   <= num3_nxt;
    end
    if (rdy4) begin
      wd4_r   <= dinfo3_r.bad ? '0 : wd3_r;
      doy4_r  <= dinfo3_r.bad ? '0 : dinfo3_r.doy;
      week4_r <= dinfo3_r.bad ? '0 : week4_nxt;
      mlen4_r <= dinfo3_r.mlen;
      leap4_r <= yinfo3_r.leap_y;
      bad4_r  <= dinfo3_r.bad;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'd0, bad4_r, leap4_r, mlen4_r, week4_r, doy4_r, wd4_r};

`ifndef NO_ASSERTIONS
  // input stalls only when the whole pipeline is full behind a held result
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v0_r && v1_r && v2_r && v3_r && out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

  a_good_date_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !bad4_r) |-> (week4_r != '0 && week4_r <= WEEKS_LONG
      && wd4_r <= 3'd6 && doy4_r != '0 && doy4_r <= 9'd366 && mlen4_r >= 5'd28))
    else $error("valid date with out-of-range result fields");

  a_bad_date_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && bad4_r) |-> (wd4_r == '0 && doy4_r == '0 && week4_r == '0))
    else $error("bad date with nonzero result fields");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/giwc_year_split.sv -----
`default_nettype none
module giwc_year_split
  import giwc_pkg::*;
(
  input  wire logic [BYEAR_W-1:0] prev_year,  // biased year - 1
  input  wire logic [CENT_W-1:0]  cent,       // prev_year / 100
  output year_info_t              info
);

  logic [BYEAR_W-1:0] cent_x100;
  logic [6:0]         rem;
  logic [15:0]        days;

  always_comb begin
    cent_x100 = BYEAR_W'(cent) * CENTURY;
    rem       = 7'(prev_year - cent_x100);
    // day count of whole years before this one, plus Jan 1
    days      = 16'(prev_year) + 16'(prev_year[BYEAR_W-1:2]) - 16'(cent)
              + 16'(cent[CENT_W-1:2]) + 16'd1;
    info.jan1   = mod7(days);
    // this year = prev_year + 1: century year when rem wraps at 99
    info.leap_y = (prev_year[1:0] == 2'd3 && rem != 7'd99)
               || (rem == 7'd99 && cent[1:0] == 2'd3);
    info.leap_p = prev_year[1:0] == 2'd0 && (rem != 7'd0 || cent[1:0] == 2'd0);
  end

endmodule
`default_nettype wire

// ----- rtl/core/giwc_date_check.sv -----
`default_nettype none
module giwc_date_check
  import giwc_pkg::*;
(
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic               leap,
  output date_info_t              info
);

  always_comb begin
    info.mlen = month_len(month, leap);
    info.doy  = days_before(month) + DOY_W'(day)
              + DOY_W'(leap && month > MONTH_FEB);
    // invalid month gives length 0, so any day fails
    info.bad  = day == '0 || day > info.mlen;
  end

endmodule
`default_nettype wire

// ----- rtl/core/giwc_week_sel.sv -----
`default_nettype none
module giwc_week_sel
  import giwc_pkg::*;
(
  input  wire logic [DOY_W-1:0] num,   // doy + 10 - iso weekday
  input  wire year_info_t       yinfo,
  output logic [WEEK_W-1:0]     week
);

  logic [18:0]       prod;
  logic [WEEK_W-1:0] raw;
  logic [3:0]        jp_sum;
  logic [WD_W-1:0]   jan1_prev;
  logic [WEEK_W-1:0] weeks_cur;
  logic [WEEK_W-1:0] weeks_prev;

  always_comb begin
    prod = 19'(num) * 19'(RECIP_7);
    raw  = prod[RECIP_7_SH +: WEEK_W];
    // previous Jan 1 is 365 or 366 days earlier
    jp_sum = 4'(yinfo.jan1) + 4'd6 - 4'(yinfo.leap_p);
    jan1_prev = (jp_sum >= 4'd7) ? 3'(jp_sum - 4'd7) : jp_sum[2:0];
    weeks_cur  = iso_weeks(yinfo.jan1, yinfo.leap_y);
    weeks_prev = iso_weeks(jan1_prev, yinfo.leap_p);
    priority if (raw == '0) begin
      week = weeks_prev;
    end else if (raw > weeks_cur) begin
      week = WEEK_FIRST;
    end else begin
      week = raw;
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb
  import giwc_pkg::*;
;

  localparam int unsigned RANDOM_N    = 600;
  localparam int unsigned DIRECTED_N  = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 32;

  typedef struct packed {
    logic [WD_W-1:0]   weekday;
    logic [DOY_W-1:0]  day_of_year;
    logic [WEEK_W-1:0] iso_week;
    logic [MLEN_W-1:0] month_length;
    logic              leap_year;
    logic              bad_date;
  } calendar_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               known;  // want is typed in, not predicted
    calendar_t          want;
  } date_case_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  calendar_t   pending_results[$];
  date_case_t  directed_dates [DIRECTED_N];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;

  gregorian_iso_week_calculator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  // y is the year plus one 400-year cycle throughout
  function automatic bit leap_of_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
    case (m)
      2:           return leap_of_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
    int unsigned yy;
    int unsigned shift;
    yy = (m < 3) ? y - 1 : y;
    case (m)
      1, 5:    shift = 0;
      2, 6:    shift = 3;
      3, 11:   shift = 2;
      4, 7:    shift = 5;
      8:       shift = 1;
      9, 12:   shift = 4;
      10:      shift = 6;
      default: shift = 0;
    endcase
    return (yy + yy / 4 - yy / 100 + yy / 400 + shift + d) % 7;
  endfunction

  function automatic int unsigned weeks_in(input int unsigned y);
    int unsigned jan1;
    jan1 = day_of_week(y, 1, 1);
    if (jan1 == WD_THU || (jan1 == WD_WED && leap_of_year(y))) return int'(WEEKS_LONG);
    return int'(WEEKS_SHORT);
  endfunction

  function automatic calendar_t predict_calendar(input logic [YEAR_W-1:0] yr,
                                                 input logic [MONTH_W-1:0] mo,
                                                 input logic [DAY_W-1:0] dy);
    calendar_t   r;
    int unsigned y, m, doy, wd, wmon, raw, mlen;
    r = '0;
    r.bad_date = 1'b1;
    y = int'(yr) + 400;
    r.leap_year = leap_of_year(y);
    if (mo >= 1 && mo <= 12) begin
      mlen = days_in(y, mo);
      r.month_length = MLEN_W'(mlen);
      if (dy >= 1 && dy <= mlen) begin
        r.bad_date = 1'b0;
        doy = dy;
        for (m = 1; m < mo; m++) doy += days_in(y, m);
        wd = day_of_week(y, mo, dy);
        wmon = (wd == WD_SUN) ? 7 : wd;
        raw = (doy + ISO_BIAS - wmon) / 7;
        r.weekday = WD_W'(wd);
        r.day_of_year = DOY_W'(doy);
        if (raw < 1) r.iso_week = WEEK_W'(weeks_in(y - 1));
        else if (raw > weeks_in(y)) r.iso_week = WEEK_FIRST;
        else r.iso_week = WEEK_W'(raw);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch on %s at cycle %0d: got %0d, want %0d",
             what, cycle_count, got, want);
    error_count++;
  endtask

  task automatic send_date(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
                           input logic [DAY_W-1:0] dy, input calendar_t want);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, dy, mo, yr};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(want);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int unsigned stall;
    calendar_t   got, want;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 24) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 14);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.weekday      = out_tdata[2:0];
      got.day_of_year  = out_tdata[11:3];
      got.iso_week     = out_tdata[17:12];
      got.month_length = out_tdata[22:18];
      got.leap_year    = out_tdata[23];
      got.bad_date     = out_tdata[24];
      if (pending_results.size() == 0) begin
        $display("tb: result with nothing pending at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.weekday !== want.weekday)
          report_mismatch("weekday", got.weekday, want.weekday);
        if (got.day_of_year !== want.day_of_year)
          report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
        if (got.iso_week !== want.iso_week)
          report_mismatch("iso_week", got.iso_week, want.iso_week);
        if (got.month_length !== want.month_length)
          report_mismatch("month_length", got.month_length, want.month_length);
        if (got.leap_year !== want.leap_year)
          report_mismatch("leap_year", got.leap_year, want.leap_year);
        if (got.bad_date !== want.bad_date)
          report_mismatch("bad_date", got.bad_date, want.bad_date);
      end
    end
  end

  initial begin
    int unsigned        i, pick;
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   dy;
    calendar_t          want;

    // known rows: {weekday, day_of_year, iso_week, month_length, leap, bad}
    directed_dates = '{
      '{14'd0,     4'd1,  5'd1,  1'b0, '0},
      '{14'd16383, 4'd12, 5'd31, 1'b0, '0},
      '{14'd16383, 4'd15, 5'd31, 1'b1, '{3'd0, 9'd0, 6'd0, 5'd0, 1'b0, 1'b1}},
      '{14'd0,     4'd0,  5'd0,  1'b1, '{3'd0, 9'd0, 6'd0, 5'd0, 1'b1, 1'b1}},
      '{14'd2023,  4'd2,  5'd29, 1'b1, '{3'd0, 9'd0, 6'd0, 5'd28, 1'b0, 1'b1}},
      '{14'd1900,  4'd2,  5'd29, 1'b1, '{3'd0, 9'd0, 6'd0, 5'd28, 1'b0, 1'b1}},
      '{14'd2023,  4'd4,  5'd31, 1'b1, '{3'd0, 9'd0, 6'd0, 5'd30, 1'b0, 1'b1}},
      '{14'd2023,  4'd1,  5'd0,  1'b1, '{3'd0, 9'd0, 6'd0, 5'd31, 1'b0, 1'b1}},
      '{14'd2024,  4'd13, 5'd1,  1'b1, '{3'd0, 9'd0, 6'd0, 5'd0, 1'b1, 1'b1}},
      '{14'd2024,  4'd2,  5'd29, 1'b0, '0},
      '{14'd2000,  4'd2,  5'd29, 1'b0, '0},
      '{14'd2024,  4'd1,  5'd1,  1'b1, '{3'd1, 9'd1, 6'd1, 5'd31, 1'b1, 1'b0}},
      '{14'd2021,  4'd1,  5'd1,  1'b1, '{3'd5, 9'd1, 6'd53, 5'd31, 1'b0, 1'b0}},
      '{14'd2024,  4'd12, 5'd30, 1'b1, '{3'd1, 9'd365, 6'd1, 5'd31, 1'b1, 1'b0}},
      '{14'd2026,  4'd1,  5'd1,  1'b0, '0},
      '{14'd2026,  4'd12, 5'd31, 1'b0, '0},
      '{14'd2020,  4'd12, 5'd31, 1'b0, '0},
      '{14'd2020,  4'd12, 5'd28, 1'b0, '0},
      '{14'd2023,  4'd12, 5'd31, 1'b0, '0},
      '{14'd2010,  4'd1,  5'd3,  1'b0, '0},
      '{14'd2015,  4'd1,  5'd4,  1'b0, '0},
      '{14'd1,     4'd1,  5'd1,  1'b0, '0},
      '{14'd9999,  4'd12, 5'd31, 1'b0, '0},
      '{14'd10922, 4'd5,  5'd16, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_N; i++) begin
      want = directed_dates[i].known ? directed_dates[i].want
           : predict_calendar(directed_dates[i].year, directed_dates[i].month,
                              directed_dates[i].day);
      send_date(directed_dates[i].year, directed_dates[i].month,
                directed_dates[i].day, want);
    end
    // hold off until the pipeline runs dry
    drain_results();

    for (i = 0; i < RANDOM_N; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        yr = YEAR_W'($urandom);
        mo = MONTH_W'($urandom);
        dy = DAY_W'($urandom);
      end else begin
        yr = (pick == 1) ? YEAR_W'($urandom) : YEAR_W'($urandom_range(1, 9999));
        mo = MONTH_W'($urandom_range(1, 12));
        dy = DAY_W'($urandom_range(1, days_in(int'(yr) + 400, mo)));
        // the ISO week wraps only near the turn of the year
        if (pick >= 7) begin
          if ($urandom_range(0, 1) == 0) begin
            mo = 4'd1;
            dy = DAY_W'($urandom_range(1, 7));
          end else begin
            mo = 4'd12;
            dy = DAY_W'($urandom_range(25, 31));
          end
        end
      end
      send_date(yr, mo, dy, predict_calendar(yr, mo, dy));
      if (i == RANDOM_N / 2) drain_results();
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/giwc_pkg.sv
rtl/core/giwc_year_split.sv
rtl/core/giwc_date_check.sv
rtl/core/giwc_week_sel.sv
rtl/core/gregorian_iso_week_calculator.sv
sim/tb.sv
